>>> rtl/lat_pkg.sv
// ----------------------------------------------------------------------------
// lat_pkg - shared types and constants of the line argument tokenizer
// Result word layout, queue entry layout, result kinds and the line limits.
// ----------------------------------------------------------------------------
package lat_pkg;

    localparam int MAX_ARGS    = 16;
    localparam int RAW_LIMIT   = 256;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_LINE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [3:0]  arg_index;
        logic [4:0]  arg_count;
        logic [8:0]  line_length;
        logic [15:0] consumed;
        logic        overflow;
    } res_t;

    // An entry holds the one or two result words of one accepted character
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic res_t make_token(kind_t k, logic [7:0] d, logic [3:0] idx);
        res_t r;
        r           = '0;
        r.kind      = k;
        r.data_byte = d;
        r.arg_index = idx;
        return r;
    endfunction

    function automatic res_t make_line(logic [4:0] cnt, logic [8:0] len,
                                       logic [15:0] cons, logic ovf);
        res_t r;
        r             = '0;
        r.kind        = KIND_LINE;
        r.arg_count   = cnt;
        r.line_length = len;
        r.consumed    = cons;
        r.overflow    = ovf;
        return r;
    endfunction

endpackage

>>> rtl/lat_front.sv
// ----------------------------------------------------------------------------
// lat_front - character classifier and line state
// Classifies each accepted character, advances the line state and builds the
// result words it causes.
// ----------------------------------------------------------------------------
module lat_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      ch,
    output logic            push,
    output lat_pkg::entry_t entry
);
    import lat_pkg::*;

    typedef enum logic [1:0] {
        MODE_SCAN = 2'd0,
        MODE_COPY = 2'd1,
        MODE_CLIP = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CLS_TEXT = 2'd0,
        CLS_SEP  = 2'd1,
        CLS_RET  = 2'd2,
        CLS_NUL  = 2'd3
    } cls_t;

    mode_t       mode_reg, mode_next;
    logic [4:0]  tc_reg, tc_next;
    logic [8:0]  rl_reg, rl_next;
    logic [15:0] cc_reg, cc_next;
    logic        tm_reg, tm_next;

    cls_t        cls;
    logic [1:0]  n;
    logic        do_scan;
    res_t        r;
    res_t        res0, res1;

    always_comb
    begin
        if (ch == CH_NUL)
            cls = CLS_NUL;
        else if (ch == CH_LF || ch == CH_CR)
            cls = CLS_RET;
        else if (ch <= CH_SPACE || ch == CH_COMMA || ch[7])
            cls = CLS_SEP;
        else
            cls = CLS_TEXT;
    end

    always_comb
    begin
        mode_next = mode_reg;
        tc_next   = tc_reg;
        rl_next   = rl_reg;
        cc_next   = cc_reg;
        tm_next   = tm_reg;
        n         = 2'd0;
        do_scan   = 1'b0;
        r         = '0;
        res0      = '0;
        res1      = '0;

        unique case (mode_reg)
            MODE_CLIP:
            begin
                if (cls == CLS_RET)
                begin
                    if (cc_next != 16'hFFFF)
                        cc_next = cc_next + 16'd1;
                end
                else
                begin
                    // close the line, this character opens the next one
                    res0      = make_line(tc_next, rl_next, cc_next, tm_next);
                    n         = 2'd1;
                    tc_next   = '0;
                    rl_next   = 9'd1;
                    cc_next   = 16'd1;
                    tm_next   = 1'b0;
                    mode_next = MODE_SCAN;
                    do_scan   = 1'b1;
                end
            end
            MODE_COPY:
            begin
                if (rl_next < 9'(RAW_LIMIT))
                    rl_next = rl_next + 9'd1;
                if (cc_next != 16'hFFFF)
                    cc_next = cc_next + 16'd1;
                if (cls == CLS_TEXT)
                begin
                    if (!tm_next)
                    begin
                        res0 = make_token(KIND_BYTE, ch, 4'(tc_next - 5'd1));
                        n    = 2'd1;
                    end
                end
                else
                begin
                    if (!tm_next)
                    begin
                        res0 = make_token(KIND_END, 8'd0, 4'(tc_next - 5'd1));
                        n    = 2'd1;
                    end
                    mode_next = MODE_SCAN;
                    do_scan   = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_SCAN;
                if (rl_next < 9'(RAW_LIMIT))
                    rl_next = rl_next + 9'd1;
                if (cc_next != 16'hFFFF)
                    cc_next = cc_next + 16'd1;
                do_scan = 1'b1;
            end
        endcase

        if (do_scan)
        begin
            unique case (cls)
                CLS_TEXT:
                begin
                    if (tc_next < 5'(MAX_ARGS))
                    begin
                        r = make_token(KIND_BYTE, ch, tc_next[3:0]);
                        if (n == 2'd0)
                            res0 = r;
                        else
                            res1 = r;
                        n       = n + 2'd1;
                        tc_next = tc_next + 5'd1;
                    end
                    else
                        tm_next = 1'b1;
                    mode_next = MODE_COPY;
                end
                CLS_RET:
                    mode_next = MODE_CLIP;
                CLS_NUL:
                begin
                    r = make_line(tc_next, rl_next, cc_next, tm_next);
                    if (n == 2'd0)
                        res0 = r;
                    else
                        res1 = r;
                    n         = n + 2'd1;
                    tc_next   = '0;
                    rl_next   = '0;
                    cc_next   = '0;
                    tm_next   = 1'b0;
                    mode_next = MODE_SCAN;
                end
                default: ;
            endcase
        end
    end

    assign push      = accept && (n != 2'd0);
    assign entry.two = (n == 2'd2);
    assign entry.r0  = res0;
    assign entry.r1  = res1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SCAN;
            tc_reg   <= '0;
            rl_reg   <= '0;
            cc_reg   <= '0;
            tm_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            tc_reg   <= tc_next;
            rl_reg   <= rl_next;
            cc_reg   <= cc_next;
            tm_reg   <= tm_next;
        end
    end

endmodule

>>> rtl/lat_queue.sv
// ----------------------------------------------------------------------------
// lat_queue - short entry queue between front and back
// Register FIFO of result entries; head entry is shown for the back to read.
// ----------------------------------------------------------------------------
module lat_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lat_pkg::entry_t   wr_entry,
    input  logic              pop,
    output lat_pkg::entry_t   head,
    output lat_pkg::q_stat_t  stat
);
    import lat_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/lat_back.sv
// ----------------------------------------------------------------------------
// lat_back - result serialiser and output register
// Unpacks queue entries into single result words, one per unstalled cycle.
// ----------------------------------------------------------------------------
module lat_back (
    input  logic             clk,
    input  logic             rst_n,
    input  lat_pkg::entry_t  head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output lat_pkg::res_t    out_res,
    output logic             out_last
);
    import lat_pkg::*;

    logic  valid_reg, valid_next;
    logic  sel_reg, sel_next;
    res_t  res_reg, res_next;
    logic  last_reg, last_next;
    logic  load;

    // take the next word when the output register is free or being drained
    assign load = !empty && (!valid_reg || out_ready);
    assign pop  = load && (!head.two || sel_reg);

    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            res_next   = sel_reg ? head.r1 : head.r0;
            last_next  = sel_reg || !head.two;
            sel_next   = head.two && !sel_reg;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

endmodule

>>> rtl/line_argument_tokenizer.sv
// ----------------------------------------------------------------------------
// line_argument_tokenizer - splits a character stream into lines and arguments
// Front classifies characters and tracks the line; back delivers result words.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | word
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | ch
//  out     | out_valid / out_ready| kind, data_byte, arg_index, arg_count,
//          |                      | line_length, consumed, overflow, last
//
//  One character is accepted per cycle; its line state update happens in the
//  same cycle in the front. The back delivers one result word per cycle while
//  out_ready is high, so a character with two results holds the output port for
//  both words; a four entry queue absorbs these bursts and in_ready drops only
//  when it is full. Results go through the queue, then the output register.
//  Reset clears line state, queue pointers and output valid; no clearing pass.
//
module line_argument_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [3:0]  arg_index,
    output logic [4:0]  arg_count,
    output logic [8:0]  line_length,
    output logic [15:0] consumed,
    output logic        overflow,
    output logic        last
);
    import lat_pkg::*;

    logic     accept;
    logic     q_push;
    logic     q_pop;
    entry_t   q_wr_entry;
    entry_t   q_head;
    q_stat_t  q_stat;
    res_t     out_res;

    // accept a word whenever the queue has room
    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    lat_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ch     (ch),
        .push   (q_push),
        .entry  (q_wr_entry)
    );

    lat_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    lat_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_stat.empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res),
        .out_last  (last)
    );

    // drive result fields from the output register
    assign kind        = out_res.kind;
    assign data_byte   = out_res.data_byte;
    assign arg_index   = out_res.arg_index;
    assign arg_count   = out_res.arg_count;
    assign line_length = out_res.line_length;
    assign consumed    = out_res.consumed;
    assign overflow    = out_res.overflow;

    // never write into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    // never read from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    // line summary fields stay zero on token words
    a_token_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_LINE) |->
            (arg_count == 5'd0 && line_length == 9'd0 && consumed == 16'd0 && !overflow))
        else $error("line fields set on a token word");

    // a word that is not the last of its character is followed by another
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("second word of a pair missing");

endmodule

>>> tb/line_argument_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// line_argument_tokenizer_tb - self-checking bench for the line tokenizer
// Feeds a short table of hand-picked characters, then random lines made of
// tokens, separators, NULs and return runs mixed with raw noise, and a final
// line of many short arguments, long enough to saturate the length count and
// to run past the argument limit. Every result word is checked field by field
// against an in-bench line predictor, under three idling patterns on the
// character and result channels.
// ----------------------------------------------------------------------------
module line_argument_tokenizer_tb;

    import lat_pkg::*;

    localparam int N_DIRECTED   = 25;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_CHARS  = 40;
    localparam int LONG_ARGS    = 140;

    // Character classes of the text stream
    typedef enum logic [1:0] {
        CC_TEXT,
        CC_SEP,
        CC_RET,
        CC_NUL
    } char_class_t;

    // Where the predictor stands within the current line
    typedef enum logic [1:0] {
        LS_IDLE,     // between arguments
        LS_TOKEN,    // inside an argument
        LS_RETURNS   // inside a run of returns
    } line_state_t;

    // One result word as the bench awaits it
    typedef struct packed {
        res_t r;
        logic last;
    } out_word_t;

    // One row of the directed table: typed rows carry their words, the rest
    // are left to the predictor
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        logic [1:0] n_words;
        out_word_t  w0;
        out_word_t  w1;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [3:0]  arg_index;
    logic [4:0]  arg_count;
    logic [8:0]  line_length;
    logic [15:0] consumed;
    logic        overflow;
    logic        last;

    // Predictor state: a private copy of the line tracking
    line_state_t line_state   = LS_IDLE;
    logic [4:0]  arg_total    = '0;
    logic [8:0]  line_chars   = '0;
    logic [15:0] line_consumed = '0;
    logic        arg_overflow = 1'b0;

    // Words caused by the character just accepted
    out_word_t   step_words [2];
    int          step_n;

    // Result words still to arrive, oldest first
    out_word_t   awaited_words [$];

    int          errors        = 0;
    int          cycle_count   = 0;
    int          chars_sent    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    line_argument_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .arg_index   (arg_index),
        .arg_count   (arg_count),
        .line_length (line_length),
        .consumed    (consumed),
        .overflow    (overflow),
        .last        (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Word builders, shared by the table and the predictor
    // ------------------------------------------------------------------
    function automatic out_word_t word_tok(kind_t k, logic [7:0] d, logic [3:0] idx,
                                           logic lst);
        out_word_t w;
        w             = '0;
        w.r.kind      = k;
        w.r.data_byte = d;
        w.r.arg_index = idx;
        w.last        = lst;
        return w;
    endfunction

    function automatic out_word_t word_line(logic [4:0] cnt, logic [8:0] len,
                                            logic [15:0] cons, logic ovf, logic lst);
        out_word_t w;
        w               = '0;
        w.r.kind        = KIND_LINE;
        w.r.arg_count   = cnt;
        w.r.line_length = len;
        w.r.consumed    = cons;
        w.r.overflow    = ovf;
        w.last          = lst;
        return w;
    endfunction

    function automatic stim_row_t row_typed(logic [7:0] c, logic [1:0] n,
                                            out_word_t w0, out_word_t w1);
        stim_row_t row;
        row.ch      = c;
        row.typed   = 1'b1;
        row.n_words = n;
        row.w0      = w0;
        row.w1      = w1;
        return row;
    endfunction

    function automatic stim_row_t row_predicted(logic [7:0] c);
        stim_row_t row;
        row       = '0;
        row.ch    = c;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------
    function automatic char_class_t class_of(logic [7:0] c);
        if (c == CH_NUL)
            return CC_NUL;
        if (c == CH_LF || c == CH_CR)
            return CC_RET;
        // bytes from 0x80 up count as negative, hence separators
        if (c <= CH_SPACE || c == CH_COMMA || c[7])
            return CC_SEP;
        return CC_TEXT;
    endfunction

    task automatic add_word(input out_word_t w);
        step_words[step_n] = w;
        step_n++;
    endtask

    task automatic bump_consumed();
        if (line_consumed != 16'hFFFF)
            line_consumed = line_consumed + 16'd1;
    endtask

    task automatic count_char();
        if (int'(line_chars) < RAW_LIMIT)
            line_chars = line_chars + 9'd1;
        bump_consumed();
    endtask

    // Report the line and start a fresh one
    task automatic close_line();
        add_word(word_line(arg_total, line_chars, line_consumed, arg_overflow, 1'b0));
        arg_total     = '0;
        line_chars    = '0;
        line_consumed = '0;
        arg_overflow  = 1'b0;
    endtask

    // Handle a character seen between arguments
    task automatic scan_char(input char_class_t cls, input logic [7:0] c);
        case (cls)
            CC_TEXT:
            begin
                if (int'(arg_total) < MAX_ARGS)
                begin
                    add_word(word_tok(KIND_BYTE, c, 4'(arg_total), 1'b0));
                    arg_total = arg_total + 5'd1;
                end
                else
                begin
                    arg_overflow = 1'b1;
                end
                line_state = LS_TOKEN;
            end
            CC_RET:
            begin
                line_state = LS_RETURNS;
            end
            CC_NUL:
            begin
                close_line();
                line_state = LS_IDLE;
            end
            default:
            begin
            end
        endcase
    endtask

    // Work out the words that one accepted character causes
    task automatic tokenize_char(input logic [7:0] c);
        char_class_t cls;
        cls    = class_of(c);
        step_n = 0;
        case (line_state)
            LS_RETURNS:
            begin
                if (cls == CC_RET)
                begin
                    bump_consumed();
                end
                else
                begin
                    // the byte ending the run opens the next line
                    close_line();
                    line_state = LS_IDLE;
                    count_char();
                    scan_char(cls, c);
                end
            end
            LS_TOKEN:
            begin
                count_char();
                if (cls == CC_TEXT)
                begin
                    if (!arg_overflow)
                        add_word(word_tok(KIND_BYTE, c, 4'(arg_total - 5'd1), 1'b0));
                end
                else
                begin
                    if (!arg_overflow)
                        add_word(word_tok(KIND_END, 8'h00, 4'(arg_total - 5'd1), 1'b0));
                    line_state = LS_IDLE;
                    scan_char(cls, c);
                end
            end
            default:
            begin
                line_state = LS_IDLE;
                count_char();
                scan_char(cls, c);
            end
        endcase
        if (step_n > 0)
            step_words[step_n - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Character channel
    // ------------------------------------------------------------------

    // Offer one character, hold it until taken, then predict its words
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chars_sent++;
        tokenize_char(c);
        for (int i = 0; i < step_n; i++)
            awaited_words.push_back(step_words[i]);
    endtask

    function automatic logic [7:0] random_text();
        logic [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7F));
        if (c == CH_COMMA)
            c = 8'h2D;
        return c;
    endfunction

    function automatic logic [7:0] random_sep();
        logic [7:0] c;
        case ($urandom_range(2))
            0: c = CH_COMMA;
            1: c = 8'($urandom_range(8'h80, 8'hFF));
            default:
            begin
                c = 8'($urandom_range(8'h01, 8'h20));
                if (c == CH_LF || c == CH_CR)
                    c = CH_SPACE;
            end
        endcase
        return c;
    endfunction

    // One line: optional leading separators, a handful of arguments (now and
    // then more than the line can keep), closed by a NUL or a return run.
    // A return run is closed by whatever the next line starts with.
    task automatic send_line();
        int n_args;
        int n_seps;
        int tok_len;
        n_args = ($urandom_range(7) == 0) ? int'($urandom_range(17, 20))
                                          : int'($urandom_range(0, 6));
        n_seps = $urandom_range(0, 2);
        repeat (n_seps) send_char(random_sep());
        for (int a = 0; a < n_args; a++)
        begin
            tok_len = $urandom_range(1, 5);
            repeat (tok_len) send_char(random_text());
            // drop the trailing separator at times so NUL or return cuts the token
            if (a != n_args - 1 || $urandom_range(1) == 1)
            begin
                n_seps = $urandom_range(1, 2);
                repeat (n_seps) send_char(random_sep());
            end
        end
        if ($urandom_range(2) == 0)
            send_char(CH_NUL);
        else
            repeat ($urandom_range(1, 3)) send_char($urandom_range(1) ? CH_CR : CH_LF);
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct, input int n_chars);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at       = chars_sent + n_chars;
        while (chars_sent < stop_at)
        begin
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(255)));
            else
                send_line();
        end
    endtask

    // ------------------------------------------------------------------
    // Result channel: random back-pressure and the word checker
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Compare each delivered word with the oldest one awaited
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_words.size() == 0)
            begin
                $error("result word with nothing awaited: kind 0x%0h data 0x%0h",
                       kind, data_byte);
                errors++;
            end
            else
            begin
                want = awaited_words.pop_front();
                check_field("kind",        16'(want.r.kind),        16'(kind));
                check_field("data_byte",   16'(want.r.data_byte),   16'(data_byte));
                check_field("arg_index",   16'(want.r.arg_index),   16'(arg_index));
                check_field("arg_count",   16'(want.r.arg_count),   16'(arg_count));
                check_field("line_length", 16'(want.r.line_length), 16'(line_length));
                check_field("consumed",    want.r.consumed,         consumed);
                check_field("overflow",    16'(want.r.overflow),    16'(overflow));
                check_field("last",        16'(want.last),          16'(last));
            end
        end
    end

    // Hard stop if the run hangs or words never arrive
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("line_argument_tokenizer_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t directed_rows [N_DIRECTED];

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        ch        = 8'h00;
        out_ready = 1'b0;

        // Directed table. Typed rows hold words read straight off the line
        // rules; the rest go through the predictor.
        // NUL straight after reset: an empty line of one byte
        directed_rows[0]  = row_typed(CH_NUL, 2'd1,
                                      word_line(5'd0, 9'd1, 16'd1, 1'b0, 1'b1), '0);
        // top and bottom of the text range, then a comma ending the token
        directed_rows[1]  = row_typed(8'h7F, 2'd1,
                                      word_tok(KIND_BYTE, 8'h7F, 4'd0, 1'b1), '0);
        directed_rows[2]  = row_typed(8'h21, 2'd1,
                                      word_tok(KIND_BYTE, 8'h21, 4'd0, 1'b1), '0);
        directed_rows[3]  = row_typed(CH_COMMA, 2'd1,
                                      word_tok(KIND_END, 8'h00, 4'd0, 1'b1), '0);
        // separators at the edges of their ranges give nothing
        directed_rows[4]  = row_typed(8'hFF, 2'd0, '0, '0);
        directed_rows[5]  = row_typed(8'h80, 2'd0, '0, '0);
        directed_rows[6]  = row_typed(8'h01, 2'd0, '0, '0);
        directed_rows[7]  = row_typed(CH_SPACE, 2'd0, '0, '0);
        directed_rows[8]  = row_predicted(8'h78);
        // NUL inside a token: token end, then the line end
        directed_rows[9]  = row_typed(CH_NUL, 2'd2,
                                      word_tok(KIND_END, 8'h00, 4'd1, 1'b0),
                                      word_line(5'd2, 9'd9, 16'd9, 1'b0, 1'b1));
        directed_rows[10] = row_predicted(8'h61);
        directed_rows[11] = row_predicted(CH_CR);
        // further returns are only counted as consumed
        directed_rows[12] = row_typed(CH_LF, 2'd0, '0, '0);
        directed_rows[13] = row_typed(CH_CR, 2'd0, '0, '0);
        // text ending the return run: line end, then a token byte of the new line
        directed_rows[14] = row_typed(8'h62, 2'd2,
                                      word_line(5'd1, 9'd2, 16'd4, 1'b0, 1'b0),
                                      word_tok(KIND_BYTE, 8'h62, 4'd0, 1'b1));
        directed_rows[15] = row_predicted(CH_LF);
        // NUL ending the return run: two line ends back to back
        directed_rows[16] = row_typed(CH_NUL, 2'd2,
                                      word_line(5'd1, 9'd2, 16'd2, 1'b0, 1'b0),
                                      word_line(5'd0, 9'd1, 16'd1, 1'b0, 1'b1));
        directed_rows[17] = row_predicted(CH_CR);
        // separator ending the return run
        directed_rows[18] = row_typed(CH_SPACE, 2'd1,
                                      word_line(5'd0, 9'd1, 16'd1, 1'b0, 1'b1), '0);
        directed_rows[19] = row_predicted(8'h5A);
        directed_rows[20] = row_predicted(8'h7E);
        directed_rows[21] = row_predicted(8'h8F);
        directed_rows[22] = row_predicted(CH_LF);
        directed_rows[23] = row_predicted(CH_CR);
        directed_rows[24] = row_predicted(CH_NUL);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 57;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_char(directed_rows[i].ch);
            if (directed_rows[i].typed)
            begin
                // swap the predicted words for the typed ones
                repeat (step_n) void'(awaited_words.pop_back());
                if (directed_rows[i].n_words > 2'd0)
                    awaited_words.push_back(directed_rows[i].w0);
                if (directed_rows[i].n_words > 2'd1)
                    awaited_words.push_back(directed_rows[i].w1);
            end
        end

        run_random_phase(35, 57, PHASE_CHARS);
        run_random_phase(57, 35, PHASE_CHARS);
        run_random_phase(0, 0, PHASE_CHARS);

        // One line of many short arguments: saturates the length count and
        // runs well past the argument limit
        send_char(8'h71);
        repeat (LONG_ARGS)
        begin
            send_char(random_sep());
            send_char(random_text());
        end
        send_char(CH_NUL);

        in_valid <= 1'b0;

        // Wait for every awaited word, then watch a little longer for strays
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("line_argument_tokenizer_tb OK");
        else
            $display("line_argument_tokenizer_tb NOT OK");
        $finish;
    end

endmodule

>>> line_argument_tokenizer.f
rtl/lat_pkg.sv
rtl/lat_front.sv
rtl/lat_queue.sv
rtl/lat_back.sv
rtl/line_argument_tokenizer.sv
tb/line_argument_tokenizer_tb.sv
